// ----- hw/rtl/hit_pkg.sv -----
// Shared types and constants of the homography inlier test block.
package hit_pkg;

  localparam int COEF_W         = 48;
  localparam int COORD_W        = 16;
  localparam int IDX_W          = 12;
  localparam int ERR_W          = 20;
  localparam int SLOT_W         = 5;
  localparam int ROW_SLOTS      = 9;
  localparam int NUM_SLOTS      = 2 * ROW_SLOTS;
  localparam int COORD_FRAC_DEF = 4;

  // row sums, projection cap (2^40), difference cap (2^30), distance width
  localparam int SUM_W     = 64;
  localparam int PROJ_BITS = 40;
  localparam int DIFF_BITS = 30;
  localparam int DIST_W    = 32;

  localparam logic [ERR_W-1:0] ERR_MAX   = '1;
  localparam logic [ERR_W-1:0] THR_RESET = ERR_W'(48);

  // input tdata layout
  localparam int SLOT_LSB   = 0;
  localparam int VALUE_LSB  = SLOT_LSB + SLOT_W;
  localparam int INDEX_LSB  = VALUE_LSB + COEF_W;
  localparam int SRC_X_LSB  = INDEX_LSB + IDX_W;
  localparam int SRC_Y_LSB  = SRC_X_LSB + COORD_W;
  localparam int DST_X_LSB  = SRC_Y_LSB + COORD_W;
  localparam int DST_Y_LSB  = DST_X_LSB + COORD_W;
  localparam int IN_USED_W  = DST_Y_LSB + COORD_W;
  localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // output tdata / tuser layout
  localparam int ERR_LSB     = IDX_W;
  localparam int OUT_DATA_W  = IDX_W + ERR_W;
  localparam int OUT_USER_W  = 2;
  localparam int INLIER_BIT  = 0;
  localparam int DEGEN_BIT   = 1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_t;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic              vld;
    logic              zero;
    logic [DIST_W-1:0] len;
  } xfer_res_t;

endpackage

// ----- hw/rtl/hit_xfer.sv -----
// One transfer direction: map a point by a 3x3 matrix, divide by w, distance to target.
module hit_xfer #(
  parameter int COORD_FRAC_BITS = hit_pkg::COORD_FRAC_DEF,
  parameter int TAG_W           = hit_pkg::IDX_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  hit_pkg::coef_t                coef [hit_pkg::ROW_SLOTS],
  input  logic [hit_pkg::COORD_W-1:0]   x,
  input  logic [hit_pkg::COORD_W-1:0]   y,
  input  logic [hit_pkg::COORD_W-1:0]   tx,
  input  logic [hit_pkg::COORD_W-1:0]   ty,
  input  logic [TAG_W-1:0]              tag_i,
  output hit_pkg::xfer_res_t            res,
  output logic [TAG_W-1:0]              tag_o
);
  import hit_pkg::*;

  localparam int PW         = COEF_W + COORD_W + 1;
  localparam int RW         = SUM_W + PROJ_BITS;
  localparam int EW         = PROJ_BITS + 3;
  localparam int DW         = DIFF_BITS + 1;
  localparam int SQW        = 2 * DW;
  localparam int ROOT_STEPS = SUM_W / 2;

  typedef struct packed {
    logic [COORD_W-1:0] tx;
    logic [COORD_W-1:0] ty;
    logic [TAG_W-1:0]   tag;
  } side_t;

  typedef struct packed {
    logic [RW-1:0]        rem_x;
    logic [RW-1:0]        rem_y;
    logic [PROJ_BITS-1:0] q_x;
    logic [PROJ_BITS-1:0] q_y;
    logic [SUM_W-1:0]     ud;
    logic                 sat_x;
    logic                 sat_y;
    logic                 neg_x;
    logic                 neg_y;
    logic                 zero;
    side_t                side;
  } div_t;

  typedef struct packed {
    logic [SUM_W-1:0] v;
    logic [SUM_W-1:0] root;
    logic             zero;
    logic [TAG_W-1:0] tag;
  } root_t;

  // ---- stage 1: products, each term floored by 4
  logic signed [PW-1:0]    prod_a [3];
  logic signed [PW-1:0]    prod_b [3];
  logic signed [PW-1:0]    cext   [3];
  logic signed [SUM_W-1:0] ta_nxt [3];
  logic signed [SUM_W-1:0] tb_nxt [3];
  logic signed [SUM_W-1:0] tc_nxt [3];
  logic signed [SUM_W-1:0] ta_r   [3];
  logic signed [SUM_W-1:0] tb_r   [3];
  logic signed [SUM_W-1:0] tc_r   [3];
  side_t                   s1_r;
  logic                    v1_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod_a[r] = coef[3*r] * $signed({1'b0, x});
      prod_b[r] = coef[3*r+1] * $signed({1'b0, y});
      cext[r]   = PW'(coef[3*r+2]) <<< COORD_FRAC_BITS;
      ta_nxt[r] = SUM_W'(prod_a[r] >>> 2);
      tb_nxt[r] = SUM_W'(prod_b[r] >>> 2);
      tc_nxt[r] = SUM_W'(cext[r] >>> 2);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ta_r <= ta_nxt;
      tb_r <= tb_nxt;
      tc_r <= tc_nxt;
      s1_r <= '{tx: tx, ty: ty, tag: tag_i};
    end
  end

  // ---- stage 2: row sums
  logic signed [SUM_W-1:0] sum_r [3];
  side_t                   s2_r;
  logic                    v2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) sum_r[r] <= ta_r[r] + tb_r[r] + tc_r[r];
      s2_r <= s1_r;
    end
  end

  // ---- stage 3: magnitudes and quotient signs
  logic [SUM_W-1:0] un_x_r, un_y_r, ud_r;
  logic             neg_x_r, neg_y_r, zero3_r;
  side_t            s3_r;
  logic             v3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      un_x_r  <= sum_r[0][SUM_W-1] ? SUM_W'(-sum_r[0]) : SUM_W'(sum_r[0]);
      un_y_r  <= sum_r[1][SUM_W-1] ? SUM_W'(-sum_r[1]) : SUM_W'(sum_r[1]);
      ud_r    <= sum_r[2][SUM_W-1] ? SUM_W'(-sum_r[2]) : SUM_W'(sum_r[2]);
      neg_x_r <= sum_r[0][SUM_W-1] ^ sum_r[2][SUM_W-1];
      neg_y_r <= sum_r[1][SUM_W-1] ^ sum_r[2][SUM_W-1];
      zero3_r <= (sum_r[2] == '0);
      s3_r    <= s2_r;
    end
  end

  // ---- stage 4: saturation test, divider setup
  div_t             div_r   [PROJ_BITS+1];
  logic             dvld_r  [PROJ_BITS+1];
  div_t             div0_nxt;
  logic [RW-1:0]    dividend_x, dividend_y, den_top;

  always_comb begin
    dividend_x        = RW'(un_x_r) << COORD_FRAC_BITS;
    dividend_y        = RW'(un_y_r) << COORD_FRAC_BITS;
    den_top           = RW'(ud_r) << PROJ_BITS;
    div0_nxt          = '0;
    div0_nxt.rem_x    = dividend_x;
    div0_nxt.rem_y    = dividend_y;
    div0_nxt.ud       = ud_r;
    div0_nxt.sat_x    = (dividend_x >= den_top);
    div0_nxt.sat_y    = (dividend_y >= den_top);
    div0_nxt.neg_x    = neg_x_r;
    div0_nxt.neg_y    = neg_y_r;
    div0_nxt.zero     = zero3_r;
    div0_nxt.side     = s3_r;
  end

  always_ff @(posedge clk) begin
    if (en) div_r[0] <= div0_nxt;
  end

  // ---- restoring divider, one quotient bit per stage
  for (genvar n = 1; n <= PROJ_BITS; n++) begin : g_div
    localparam int B = PROJ_BITS - n;
    div_t          stage_nxt;
    logic [RW-1:0] trial;

    always_comb begin
      stage_nxt = div_r[n-1];
      trial     = RW'(div_r[n-1].ud) << B;
      if (div_r[n-1].rem_x >= trial) begin
        stage_nxt.rem_x  = div_r[n-1].rem_x - trial;
        stage_nxt.q_x[B] = 1'b1;
      end
      if (div_r[n-1].rem_y >= trial) begin
        stage_nxt.rem_y  = div_r[n-1].rem_y - trial;
        stage_nxt.q_y[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) div_r[n] <= stage_nxt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r[n] <= 1'b0;
      end else if (en) begin
        dvld_r[n] <= dvld_r[n-1];
      end
    end
  end

  // ---- stage 5: signed projection, clamped difference magnitude
  div_t            dq;
  logic [EW-1:0]   pmag_x, pmag_y, ps_x, ps_y, diff_x, diff_y;
  logic [EW-1:0]   cl_x, cl_y;
  logic [DW-1:0]   dxm_nxt, dym_nxt, dxm_r, dym_r;
  logic            zero5_r;
  logic [TAG_W-1:0] tag5_r;
  logic            v5_r;
  localparam logic [EW-1:0] CAP  = EW'(1) << DIFF_BITS;
  localparam logic [EW-1:0] NCAP = EW'(0) - CAP;
  localparam logic [EW-1:0] PCAP = EW'(1) << PROJ_BITS;

  always_comb begin
    dq     = div_r[PROJ_BITS];
    pmag_x = dq.sat_x ? PCAP : EW'(dq.q_x);
    pmag_y = dq.sat_y ? PCAP : EW'(dq.q_y);
    ps_x   = dq.neg_x ? EW'(0) - pmag_x : pmag_x;
    ps_y   = dq.neg_y ? EW'(0) - pmag_y : pmag_y;
    diff_x = EW'(dq.side.tx) - ps_x;
    diff_y = EW'(dq.side.ty) - ps_y;
    if ($signed(diff_x) > $signed(CAP))       cl_x = CAP;
    else if ($signed(diff_x) < $signed(NCAP)) cl_x = NCAP;
    else                                      cl_x = diff_x;
    if ($signed(diff_y) > $signed(CAP))       cl_y = CAP;
    else if ($signed(diff_y) < $signed(NCAP)) cl_y = NCAP;
    else                                      cl_y = diff_y;
    dxm_nxt = cl_x[EW-1] ? DW'(EW'(0) - cl_x) : DW'(cl_x);
    dym_nxt = cl_y[EW-1] ? DW'(EW'(0) - cl_y) : DW'(cl_y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dxm_r   <= dxm_nxt;
      dym_r   <= dym_nxt;
      zero5_r <= dq.zero;
      tag5_r  <= dq.side.tag;
    end
  end

  // ---- stage 6: squares
  logic [SQW-1:0]   sq_x_r, sq_y_r;
  logic             zero6_r;
  logic [TAG_W-1:0] tag6_r;
  logic             v6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x_r  <= dxm_r * dxm_r;
      sq_y_r  <= dym_r * dym_r;
      zero6_r <= zero5_r;
      tag6_r  <= tag5_r;
    end
  end

  // ---- stage 7: sum of squares, root setup
  root_t root_r  [ROOT_STEPS+1];
  logic  rvld_r  [ROOT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      root_r[0].v    <= SUM_W'(sq_x_r) + SUM_W'(sq_y_r);
      root_r[0].root <= '0;
      root_r[0].zero <= zero6_r;
      root_r[0].tag  <= tag6_r;
    end
  end

  // ---- integer square root, one result bit per stage
  for (genvar n = 1; n <= ROOT_STEPS; n++) begin : g_root
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (ROOT_STEPS - n));
    root_t            stage_nxt;
    logic [SUM_W-1:0] trial;

    always_comb begin
      stage_nxt = root_r[n-1];
      trial     = root_r[n-1].root + BIT;
      if (root_r[n-1].v >= trial) begin
        stage_nxt.v    = root_r[n-1].v - trial;
        stage_nxt.root = (root_r[n-1].root >> 1) + BIT;
      end else begin
        stage_nxt.root = root_r[n-1].root >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) root_r[n] <= stage_nxt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rvld_r[n] <= 1'b0;
      end else if (en) begin
        rvld_r[n] <= rvld_r[n-1];
      end
    end
  end

  // valid bits of the fixed stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      dvld_r[0] <= 1'b0;
      v5_r      <= 1'b0;
      v6_r      <= 1'b0;
      rvld_r[0] <= 1'b0;
    end else if (en) begin
      v1_r      <= in_vld;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      dvld_r[0] <= v3_r;
      v5_r      <= dvld_r[PROJ_BITS];
      v6_r      <= v5_r;
      rvld_r[0] <= v6_r;
    end
  end

  assign res.vld  = rvld_r[ROOT_STEPS];
  assign res.zero = root_r[ROOT_STEPS].zero;
  assign res.len  = DIST_W'(root_r[ROOT_STEPS].root);
  assign tag_o    = root_r[ROOT_STEPS].tag;

endmodule

// ----- hw/rtl/homography_inlier_test_core.sv -----
// Homography inlier test: symmetric transfer error of one correspondence per item.
//
// Input channel (in_*): tuser selects the item kind. A load item writes one of the
// 18 matrix coefficients (slots 0-8 forward, 9-17 inverse, row-major; higher slots
// are dropped) and gives no result. A test item maps the source point by the
// forward matrix and the destination point by the inverse, and gives one result:
// index, summed error (saturated), inlier flag and zero-w flag.
// Config channel (cfg_*): the distance threshold, always ready; write it only
// while no test item is in flight.
// Pipeline: an accepted test item passes the input register, four setup stages,
// a 40-stage divider (one quotient bit per stage), three stages of
// difference/square/sum, a 32-stage square root (one root bit per stage) and the
// output register, which drives out_tvalid.
// Throughput: one item per cycle while in_tready is high; later test items see loads.
// Stall: a stalled result sits in the output register; the next item from the
// pipeline drops into a one-entry skid buffer, and in_tready falls only while that
// buffer is full. Nothing is lost or repeated.
// Reset: clears valid bits and sets the threshold to 48; coefficients hold
// whatever they held until loaded.
module homography_inlier_test_core #(
  parameter int COORD_FRAC_BITS = hit_pkg::COORD_FRAC_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // coef_slot, coef_value, point_index, src_x, src_y, dst_x, dst_y, zero fill
  input  logic [hit_pkg::IN_DATA_W-1:0]    in_tdata,
  // operation
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // result_index, transfer_error
  output logic [hit_pkg::OUT_DATA_W-1:0]   out_tdata,
  // is_inlier, degenerate
  output logic [hit_pkg::OUT_USER_W-1:0]   out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hit_pkg::ERR_W-1:0]        cfg_data
);
  import hit_pkg::*;

  logic en, acc;
  op_t  op;
  logic [SLOT_W-1:0]  slot;
  coef_t              value;

  logic [ERR_W-1:0]   thr_r;
  coef_t              store_r [NUM_SLOTS];
  coef_t              fwd_coef [ROW_SLOTS];
  coef_t              inv_coef [ROW_SLOTS];

  logic               s0_vld_r;
  logic [IDX_W-1:0]   idx_r;
  logic [COORD_W-1:0] sx_r, sy_r, dx_r, dy_r;

  xfer_res_t          fres, ires;
  logic [IDX_W-1:0]   res_idx;

  logic                    degen;
  logic [DIST_W:0]         dsum;
  logic [ERR_W-1:0]        err;
  logic [OUT_DATA_W-1:0]   data_nxt;
  logic [OUT_USER_W-1:0]   user_nxt;

  logic                    out_vld_r, skid_vld_r;
  logic [OUT_DATA_W-1:0]   out_data_r, skid_data_r;
  logic [OUT_USER_W-1:0]   out_user_r, skid_user_r;

  assign en        = !skid_vld_r;
  assign in_tready = en;
  assign acc       = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser);
  assign slot      = in_tdata[SLOT_LSB +: SLOT_W];
  assign value     = in_tdata[VALUE_LSB +: COEF_W];

  // threshold register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  // coefficient store, read by the first pipeline stage
  always_ff @(posedge clk) begin
    if (acc && op == OP_LOAD && slot < SLOT_W'(NUM_SLOTS)) store_r[slot] <= value;
  end

  always_comb begin
    for (int i = 0; i < ROW_SLOTS; i++) begin
      fwd_coef[i] = store_r[i];
      inv_coef[i] = store_r[ROW_SLOTS + i];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= acc && op == OP_TEST;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r <= in_tdata[INDEX_LSB +: IDX_W];
      sx_r  <= in_tdata[SRC_X_LSB +: COORD_W];
      sy_r  <= in_tdata[SRC_Y_LSB +: COORD_W];
      dx_r  <= in_tdata[DST_X_LSB +: COORD_W];
      dy_r  <= in_tdata[DST_Y_LSB +: COORD_W];
    end
  end

  hit_xfer #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .TAG_W(IDX_W)) u_fwd (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (s0_vld_r),
    .coef   (fwd_coef),
    .x      (sx_r),
    .y      (sy_r),
    .tx     (dx_r),
    .ty     (dy_r),
    .tag_i  (idx_r),
    .res    (fres),
    .tag_o  (res_idx)
  );

  hit_xfer #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .TAG_W(IDX_W)) u_inv (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (s0_vld_r),
    .coef   (inv_coef),
    .x      (dx_r),
    .y      (dy_r),
    .tx     (sx_r),
    .ty     (sy_r),
    .tag_i  (idx_r),
    .res    (ires),
    .tag_o  ()
  );

  // combine both directions
  always_comb begin
    degen = fres.zero || ires.zero;
    dsum  = (DIST_W+1)'(fres.len) + (DIST_W+1)'(ires.len);
    if (degen || dsum > (DIST_W+1)'(ERR_MAX)) err = ERR_MAX;
    else                                      err = ERR_W'(dsum);
    data_nxt             = {err, res_idx};
    user_nxt             = '0;
    user_nxt[INLIER_BIT] = !degen && (err < thr_r);
    user_nxt[DEGEN_BIT]  = degen;
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_tready) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end
    end else if (fres.vld) begin
      if (out_vld_r && !out_tready) skid_vld_r <= 1'b1;
      else                          out_vld_r  <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
        out_user_r <= skid_user_r;
      end
    end else if (fres.vld) begin
      if (out_vld_r && !out_tready) begin
        skid_data_r <= data_nxt;
        skid_user_r <= user_nxt;
      end else begin
        out_data_r <= data_nxt;
        out_user_r <= user_nxt;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- hw/rtl/hit_chk.sv -----
// Port-level checks of the homography inlier test block, bound to the top level.
module hit_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [hit_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic [hit_pkg::OUT_USER_W-1:0]   out_tuser
);
  import hit_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_degen_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[DEGEN_BIT] |->
      out_tdata[ERR_LSB +: ERR_W] == ERR_MAX && !out_tuser[INLIER_BIT])
    else $error("zero-w result without saturated error or with inlier set");

  a_inlier_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[INLIER_BIT] |-> out_tdata[ERR_LSB +: ERR_W] != ERR_MAX)
    else $error("inlier reported with saturated error");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind homography_inlier_test_core hit_chk u_hit_chk (.*);
